>>> hdl/sfh_pkg.sv
// Shared types, constants and hash arithmetic for the byte-stream SuperFastHash unit.
// Used by sfh_front, sfh_queue, sfh_back, sfh_checker and the top level; depends on nothing.
package sfh_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 31;
  localparam int HASH_W     = 32;
  localparam int TAIL_W     = 24;
  localparam int S_TDATA_W  = ((DATA_W + LEN_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((HASH_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Number of bytes held back before a mixing round.
  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // One work item for the back end, produced by at most one input beat.
  typedef struct packed {
    logic              start;     // seed the running hash with the length
    logic [LEN_W-1:0]  seed;
    logic              mix;       // run one mixing round on word
    logic [HASH_W-1:0] word;      // four bytes, first byte in the low bits
    logic              fin;       // last byte: tail rule and avalanche follow
    logic              zero;      // zero-length message, result is 0
    logic [1:0]        tail_cnt;
    logic [TAIL_W-1:0] tail;
  } op_t;

  // Finishing pipeline entry.
  typedef struct packed {
    logic              zero;
    logic [1:0]        tail_cnt;
    logic [TAIL_W-1:0] tail;
    logic [HASH_W-1:0] h;
  } fin_t;

  function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
    return {{(HASH_W-8){b[7]}}, b};
  endfunction

  // One four-byte round, halves read little-endian.
  function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] h_in,
                                                   input logic [HASH_W-1:0] w);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] t;
    h = h_in + {16'd0, w[15:0]};
    t = ({16'd0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  // Folds the one, two or three leftover bytes into the hash.
  function automatic logic [HASH_W-1:0] tail_rule(input logic [HASH_W-1:0] h_in,
                                                   input logic [1:0] cnt,
                                                   input logic [TAIL_W-1:0] tl);
    logic [HASH_W-1:0] h;
    h = h_in;
    case (cnt)
      CNT_THREE: begin
        h = h + {16'd0, tl[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(tl[23:16]) << 18);
        h = h + (h >> 11);
      end
      CNT_TWO: begin
        h = h + {16'd0, tl[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      CNT_ONE: begin
        h = h + sext8(tl[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    return h;
  endfunction

  // First half of the avalanche.
  function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  // Second half of the avalanche.
  function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

>>> hdl/superfasthash_byte_stream_unit.sv
// Top level of the byte-stream SuperFastHash unit.
// Depends on sfh_pkg, sfh_front, sfh_queue and sfh_back.
//
// Takes one message byte per beat and returns the 32-bit SuperFastHash of
// each message as one output beat. The first beat of a message carries its
// byte length; a length of zero returns a hash of 0. The unit accepts
// a byte every clock cycle while the four-entry work queue has room; the
// queue fills only when the output side holds back. After its last byte is
// accepted, the hash of a message passes through the work queue, the mixing
// stage and the three finishing stages (tail rule, two halves of the
// avalanche), the last of which is the output register.
module superfasthash_byte_stream_unit
  import sfh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] data_byte, [38:8] message_length, [39] unused
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] hash_value
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic              full;
  logic              in_fire;
  logic              push;
  op_t               push_op;
  logic              head_valid;
  op_t               head;
  logic              pop;
  logic [HASH_W-1:0] hash_value;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = M_TDATA_W'(hash_value);

  sfh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .data_byte      (s_axis_tdata[DATA_W-1:0]),
    .message_length (s_axis_tdata[DATA_W+LEN_W-1:DATA_W]),
    .push           (push),
    .push_op        (push_op)
  );

  sfh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  sfh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_hash   (hash_value)
  );

endmodule

>>> hdl/sfh_front.sv
// Front end: takes message bytes, tracks the byte count, packs groups of four
// and issues at most one work item per beat to the queue. Depends on sfh_pkg.
module sfh_front
  import sfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [LEN_W-1:0]  message_length,
  output logic              push,
  output op_t               push_op
);

  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [TAIL_W-1:0] pending_bytes, pending_bytes_next;
  logic [1:0]        pending_count, pending_count_next;

  logic              first;
  logic [LEN_W-1:0]  bl_eff;
  logic [TAIL_W-1:0] pend_eff;
  logic [1:0]        cnt_eff;
  logic [TAIL_W-1:0] pend_add;
  op_t               op;

  // Classify the beat and work out the next byte-count and packing state.
  always_comb begin
    first    = (bytes_left == '0);
    bl_eff   = first ? message_length : bytes_left;
    pend_eff = first ? '0 : pending_bytes;
    cnt_eff  = first ? CNT_NONE : pending_count;

    case (cnt_eff)
      CNT_NONE: pend_add = {16'd0, data_byte};
      CNT_ONE:  pend_add = {8'd0, data_byte, pend_eff[7:0]};
      CNT_TWO:  pend_add = {data_byte, pend_eff[15:0]};
      default:  pend_add = pend_eff;
    endcase

    op          = '0;
    op.start    = first;
    op.seed     = message_length;
    op.word     = {data_byte, pend_eff};

    bytes_left_next    = bytes_left;
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;

    if (first && message_length == '0) begin
      // Zero-length message: answer 0 and stay idle.
      op.start = 1'b0;
      op.zero  = 1'b1;
    end else begin
      if (cnt_eff == CNT_THREE) begin
        op.mix             = 1'b1;
        pending_bytes_next = '0;
        pending_count_next = CNT_NONE;
      end else begin
        pending_bytes_next = pend_add;
        pending_count_next = cnt_eff + 2'd1;
      end
      bytes_left_next = bl_eff - LEN_W'(1);
      if (bl_eff == LEN_W'(1)) begin
        op.fin             = 1'b1;
        op.tail_cnt        = pending_count_next;
        op.tail            = pending_bytes_next;
        pending_bytes_next = '0;
        pending_count_next = CNT_NONE;
      end
    end
  end

  assign push    = in_fire && (op.start || op.mix || op.fin || op.zero);
  assign push_op = op;

  // Message tracking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      pending_bytes <= '0;
      pending_count <= CNT_NONE;
    end else if (in_fire) begin
      bytes_left    <= bytes_left_next;
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

>>> hdl/sfh_queue.sv
// Short FIFO of work items between the front and back ends.
// Depends on sfh_pkg.
module sfh_queue
  import sfh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output op_t  head
);

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> hdl/sfh_back.sv
// Back end: keeps the running hash, runs mixing rounds, and finishes a hash
// through a three-stage tail/avalanche pipeline into the output register.
// Depends on sfh_pkg.
module sfh_back
  import sfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  op_t               head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] out_hash
);

  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] h0;
  logic [HASH_W-1:0] h1;
  logic              en;
  logic              s1_valid, s2_valid, s3_valid;
  fin_t              s1;
  logic              s2_zero, s3_zero;
  logic [HASH_W-1:0] s2_h, s3_h;

  // The whole back end advances unless a finished hash is waiting.
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  // Seed and mixing round for the item at the head of the queue.
  always_comb begin
    h0 = head.start ? {1'b0, head.seed} : hash;
    h1 = head.mix ? mix_round(h0, head.word) : h0;
  end

  // Running hash.
  always_ff @(posedge clk) begin
    if (pop) begin
      hash <= h1;
    end
  end

  // Finishing pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= '{zero: head.zero, tail_cnt: head.tail_cnt, tail: head.tail, h: h1};
      s2_zero  <= s1.zero;
      s2_h     <= tail_rule(s1.h, s1.tail_cnt, s1.tail);
      s3_zero  <= s2_zero;
      s3_h     <= aval_a(s2_h);
      out_hash <= s3_zero ? '0 : aval_b(s3_h);
    end
  end

  // Finishing pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop && (head.fin || head.zero);
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule

>>> hdl/sfh_checker.sv
// Port-level checks for the byte-stream SuperFastHash unit, bound to the top.
// Depends on sfh_pkg and superfasthash_byte_stream_unit.
module sfh_checker
  import sfh_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Leaving reset, no result is pending.
  a_out_idle_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Leaving reset, the work queue is empty and input is taken.
  a_in_ready_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> s_axis_tready)
    else $error("input not ready right after reset");

  // A result cannot appear within the pipeline depth after reset.
  a_out_needs_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
                             && !$past(rst, 4))
    else $error("result appeared too soon after reset");

endmodule

bind superfasthash_byte_stream_unit sfh_checker u_sfh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
